// ----- sv/fdc_pkg.sv -----
// fdc_pkg: shared constants, codes and types of the floppy controller command engine
// no dependencies
package fdc_pkg;

  localparam int NumDrivesDef  = 2;
  localparam int ParamSlotsDef = 5;

  typedef enum logic [3:0] {
    K_READ    = 4'd0,
    K_WRITE   = 4'd1,
    K_TIMER   = 4'd2,
    K_DBYTE   = 4'd3,
    K_WANT    = 4'd4,
    K_DONE    = 4'd5,
    K_NOTFND  = 4'd6,
    K_DATACRC = 4'd7,
    K_HDRCRC  = 4'd8,
    K_WPROT   = 4'd9
  } kind_t;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_SEEK   = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_RDID   = 3'd4;
  localparam logic [2:0] OP_FORMAT = 3'd5;

  localparam logic [1:0] TM_NONE   = 2'd0;
  localparam logic [1:0] TM_ARM    = 2'd1;
  localparam logic [1:0] TM_CANCEL = 2'd2;
  localparam logic [1:0] MO_NONE   = 2'd0;
  localparam logic [1:0] MO_UP     = 2'd1;
  localparam logic [1:0] MO_DOWN   = 2'd2;

  localparam logic [2:0] A_STATUS = 3'd0;
  localparam logic [2:0] A_RESULT = 3'd1;
  localparam logic [2:0] A_RESET  = 3'd2;
  localparam logic [2:0] A_DATA   = 3'd4;

  localparam logic [7:0] C_WRITE   = 8'h0B;
  localparam logic [7:0] C_READ    = 8'h13;
  localparam logic [7:0] C_READ_AL = 8'h17;
  localparam logic [7:0] C_RDID    = 8'h1B;
  localparam logic [7:0] C_VERIFY  = 8'h1F;
  localparam logic [7:0] C_FORMAT  = 8'h23;
  localparam logic [7:0] C_SEEK    = 8'h29;
  localparam logic [7:0] C_DSTAT   = 8'h2C;
  localparam logic [7:0] C_SPEC    = 8'h35;
  localparam logic [7:0] C_WSPEC   = 8'h3A;
  localparam logic [7:0] C_RSPEC   = 8'h3D;
  localparam logic [7:0] C_NONE    = 8'hFF;

  localparam logic [7:0] R_SCAN   = 8'h06;
  localparam logic [7:0] R_TRK0   = 8'h12;
  localparam logic [7:0] R_BADTRK = 8'h17;
  localparam logic [7:0] R_TRK1   = 8'h1A;
  localparam logic [7:0] R_DOUT   = 8'h23;

  localparam logic [7:0] ST_BUSY_IRQ = 8'h8C;
  localparam logic [7:0] ST_DONE     = 8'h18;
  localparam logic [7:0] ST_RES      = 8'h10;
  localparam logic [7:0] ST_BUSY     = 8'h80;
  localparam logic [7:0] RS_BADCMD   = 8'h10;
  localparam logic [7:0] RS_NOTFND   = 8'h18;
  localparam logic [7:0] RS_DATACRC  = 8'h0E;
  localparam logic [7:0] RS_HDRCRC   = 8'h0C;
  localparam logic [7:0] RS_WPROT    = 8'h12;

  function automatic logic [2:0] needed_for(input logic [7:0] c);
    logic [2:0] n;
    begin
      case (c)
        C_SPEC:                              n = 3'd4;
        C_SEEK, C_RSPEC:                     n = 3'd1;
        C_WSPEC:                             n = 3'd2;
        C_READ, C_WRITE, C_RDID, C_VERIFY:   n = 3'd3;
        C_FORMAT:                            n = 3'd5;
        default:                             n = 3'd0;
      endcase
      return n;
    end
  endfunction

endpackage

// ----- sv/floppy_controller_command_engine.sv -----
// channel | dir | content
// in_*    | in  | tdata: kind[3:0] address[6:4] write_data[14:7] last_byte[15]
// out_*   | out | tdata: read_data, interrupt, disc_op, disc_drive, disc_track,
//         |     |        disc_sector, disc_side, timer_action, motor_action,
//         |     |        byte_valid, byte_out (48 bits)
// one transaction per cycle while the output is not stalled; the result is registered in the cycle after acceptance
// the state update and the result come from one combinational pass over the input
// in_tready is low only while a result waits and the output is stalled
// rst_n synchronous active low clears all control state; parameter slots are not reset
// depends on fdc_pkg
module floppy_controller_command_engine import fdc_pkg::*; #(
  parameter int NUM_DRIVES  = NumDrivesDef,
  parameter int PARAM_SLOTS = ParamSlotsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // kind[3:0], address[6:4], write_data[14:7], last_byte[15]
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0], interrupt[8], disc_op[11:9], disc_drive[12], disc_track[20:13],
  // disc_sector[28:21], disc_side[29], timer_action[31:30], motor_action[33:32],
  // byte_valid[34], byte_out[42:35], zero[47:43]
  output logic [47:0] out_tdata
);

  localparam int DW = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;
  localparam int PW = $clog2(PARAM_SLOTS);
  localparam logic [DW-1:0] LastDrv = DW'(NUM_DRIVES - 1);

  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  par_r [PARAM_SLOTS];
  logic [3:0]  pcnt_r, pcnt_nxt;
  logic [2:0]  pneed_r, pneed_nxt;
  logic [1:0]  dbits_r, dbits_nxt;
  logic        adrv_r, adrv_nxt;
  logic [7:0]  st_r, st_nxt, res_r, res_nxt;
  logic [7:0]  ltrk_r [NUM_DRIVES];
  logic [7:0]  ltrk_nxt [NUM_DRIVES];
  logic [7:0]  ptrk_r [NUM_DRIVES];
  logic [7:0]  ptrk_nxt [NUM_DRIVES];
  logic [7:0]  sec_r, sec_nxt;
  logic [4:0]  srem_r, srem_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        hw_r, hw_nxt, ver_r, ver_nxt;
  logic [7:0]  dout_r, dout_nxt;
  logic        pwe;
  logic [PW-1:0] pwa;

  logic [7:0] o_rd, o_trk, o_sec, o_bo;
  logic [2:0] o_op;
  logic       o_drv, o_side, o_bv;
  logic [1:0] o_tm, o_mo;

  logic        accept, ovalid_r;
  logic [47:0] odata_r;
  logic [3:0]  kind;
  logic [2:0]  addr;
  logic [7:0]  wd;
  logic        last;
  logic [DW-1:0] d;
  logic [DW-1:0] dn;
  logic [7:0]  p0, p1, p2, pval, cmdv, newtrk;
  logic [3:0]  pc_inc;
  logic        stop;

  assign in_tready = !ovalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign kind = in_tdata[3:0];
  assign addr = in_tdata[6:4];
  assign wd   = in_tdata[14:7];
  assign last = in_tdata[15];
  assign p0 = par_r[0];
  assign p1 = par_r[1];
  assign p2 = par_r[2];

  always_comb begin
    cmd_nxt = cmd_r; pcnt_nxt = pcnt_r; pneed_nxt = pneed_r; dbits_nxt = dbits_r;
    adrv_nxt = adrv_r; st_nxt = st_r; res_nxt = res_r; sec_nxt = sec_r;
    srem_nxt = srem_r; data_nxt = data_r; phase_nxt = phase_r; hw_nxt = hw_r;
    ver_nxt = ver_r; dout_nxt = dout_r;
    ltrk_nxt = ltrk_r; ptrk_nxt = ptrk_r;
    pwe = 1'b0; pwa = pcnt_r[PW-1:0]; pc_inc = pcnt_r;
    o_rd = '0; o_op = OP_NONE; o_drv = 1'b0; o_trk = '0; o_sec = '0; o_side = 1'b0;
    o_tm = TM_NONE; o_mo = MO_NONE; o_bv = 1'b0; o_bo = '0;
    d = (DW'(adrv_r) < LastDrv) ? DW'(adrv_r) : LastDrv;
    // drive selected by the command byte being written
    dn = (DW'(wd[7]) < LastDrv) ? DW'(wd[7]) : LastDrv;
    pval = '0; cmdv = '0; stop = 1'b0;
    // parameter 0 as seen by the command: freshly written when it is the first slot
    if (kind == K_WRITE && addr == A_RESULT && pcnt_r == 4'd0) pval = wd;
    else pval = p0;
    newtrk = ptrk_r[d] + pval - ltrk_r[d];
    case (kind)
      K_READ: begin
        if (addr == A_STATUS) o_rd = st_r;
        else if (addr == A_RESULT) begin
          st_nxt = st_r & ~8'h18; o_rd = res_r; res_nxt = '0;
        end else if (addr == A_DATA) begin
          st_nxt = st_r & ~8'h0C; o_rd = data_r;
        end
      end
      K_WRITE: begin
        case (addr)
          A_STATUS: begin
            if (!st_r[7]) begin
              cmdv = {2'b00, wd[5:0]};
              if (cmdv == C_READ_AL) cmdv = C_READ;
              cmd_nxt = cmdv; dbits_nxt = wd[7:6]; adrv_nxt = wd[7];
              pcnt_nxt = '0; pneed_nxt = needed_for(cmdv); st_nxt = ST_BUSY;
              if (needed_for(cmdv) == 3'd0) begin
                if (cmdv == C_DSTAT) begin
                  st_nxt = ST_RES;
                  res_nxt = 8'h88 | ((ltrk_r[dn] != 8'd0) ? 8'h00 : 8'h02)
                          | (wd[6] ? 8'h04 : 8'h00) | (wd[7] ? 8'h40 : 8'h00);
                end else begin
                  res_nxt = RS_BADCMD; st_nxt = ST_RES; o_tm = TM_CANCEL;
                end
              end
            end
          end
          A_RESULT: begin
            if (pcnt_r < 4'(PARAM_SLOTS)) begin
              pwe = 1'b1; pc_inc = pcnt_r + 4'd1; pcnt_nxt = pc_inc;
            end
            if (pc_inc == {1'b0, pneed_r}) begin
              case (cmd_r)
                C_WRITE, C_READ, C_VERIFY, C_RDID, C_FORMAT: begin
                  if (cmd_r != C_FORMAT) srem_nxt = (pcnt_r == 4'd2) ? wd[4:0] : p2[4:0];
                  if (cmd_r != C_FORMAT && cmd_r != C_RDID) sec_nxt = p1;
                  o_mo = MO_UP; phase_nxt = '0;
                  if (ltrk_r[d] != pval) begin
                    ptrk_nxt[d] = newtrk;
                    o_op = OP_SEEK; o_trk = newtrk; o_drv = adrv_r; o_side = dout_r[5];
                  end else o_tm = TM_ARM;
                  if (cmd_r == C_VERIFY) ver_nxt = 1'b1;
                end
                C_SEEK: begin
                  ptrk_nxt[d] = newtrk;
                  o_op = OP_SEEK; o_trk = newtrk; o_drv = adrv_r; o_side = dout_r[5];
                  o_mo = MO_UP;
                end
                C_SPEC: st_nxt = '0;
                C_WSPEC: begin
                  st_nxt = '0;
                  case (p0)
                    R_TRK0:   ltrk_nxt[0] = wd;
                    R_BADTRK: ;
                    R_TRK1:   if (NUM_DRIVES > 1) ltrk_nxt[NUM_DRIVES-1] = wd;
                    R_DOUT:   dout_nxt = wd;
                    default: begin res_nxt = RS_NOTFND; st_nxt = ST_DONE; o_tm = TM_CANCEL; end
                  endcase
                end
                C_RSPEC: begin
                  st_nxt = ST_RES; res_nxt = '0;
                  case (pval)
                    R_SCAN: ;
                    R_TRK0: res_nxt = ltrk_r[0];
                    R_TRK1: if (NUM_DRIVES > 1) res_nxt = ltrk_r[NUM_DRIVES-1];
                    R_DOUT: res_nxt = dout_r;
                    default: begin res_nxt = RS_NOTFND; st_nxt = ST_DONE; o_tm = TM_CANCEL; end
                  endcase
                end
                default: begin res_nxt = RS_NOTFND; st_nxt = ST_DONE; o_tm = TM_CANCEL; end
              endcase
            end
          end
          A_RESET: begin
            if (wd[0]) begin
              pcnt_nxt = '0; pneed_nxt = '0; st_nxt = '0; cmd_nxt = C_NONE;
              o_tm = TM_CANCEL;
              for (int i = 0; i < NUM_DRIVES; i++) begin
                ltrk_nxt[i] = '0; ptrk_nxt[i] = '0;
              end
            end
          end
          A_DATA: begin
            data_nxt = wd; hw_nxt = 1'b1; st_nxt = st_r & ~8'h0C;
          end
          default: ;
        endcase
      end
      K_TIMER: begin
        o_tm = TM_CANCEL;
        case (cmd_r)
          C_WRITE, C_READ, C_VERIFY, C_RDID: begin
            if (phase_r == 2'd0) begin
              ltrk_nxt[d] = p0; phase_nxt = 2'd1;
            end else begin
              srem_nxt = srem_r - 5'd1;
              if (srem_nxt == 5'd0) begin
                stop = 1'b1; st_nxt = ST_DONE; res_nxt = '0; o_mo = MO_DOWN;
                if (cmd_r != C_RDID) ver_nxt = 1'b0;
              end else sec_nxt = sec_r + 8'd1;
            end
            if (!stop) begin
              o_drv = adrv_r; o_trk = p0; o_side = dout_r[5];
              if (cmd_r == C_WRITE) begin
                o_op = OP_WRITE; o_sec = sec_nxt; st_nxt = ST_BUSY_IRQ; res_nxt = '0;
              end else if (cmd_r == C_RDID) o_op = OP_RDID;
              else begin o_op = OP_READ; o_sec = sec_nxt; end
            end
          end
          C_FORMAT: begin
            if (phase_r == 2'd0) begin
              ltrk_nxt[d] = p0; phase_nxt = 2'd1;
              o_op = OP_WRITE; o_drv = adrv_r; o_trk = p0; o_sec = sec_r;
              o_side = dout_r[5]; st_nxt = ST_BUSY_IRQ; res_nxt = '0;
            end else if (phase_r == 2'd2) begin
              st_nxt = ST_DONE; res_nxt = '0; o_mo = MO_DOWN; ver_nxt = 1'b0;
            end else begin
              o_op = OP_FORMAT; o_drv = adrv_r; o_trk = p0; o_side = dout_r[5];
              phase_nxt = 2'd2;
            end
          end
          C_SEEK: begin
            ltrk_nxt[d] = p0; st_nxt = ST_DONE; res_nxt = '0; o_mo = MO_DOWN;
          end
          default: ;
        endcase
      end
      K_DBYTE: if (!ver_r) begin data_nxt = wd; st_nxt = ST_BUSY_IRQ; res_nxt = '0; end
      K_WANT: begin
        if (hw_r) begin
          if (!last) begin st_nxt = ST_BUSY_IRQ; res_nxt = '0; end
          hw_nxt = 1'b0; o_bv = 1'b1; o_bo = data_r;
        end
      end
      K_DONE:    o_tm = TM_ARM;
      K_NOTFND:  begin res_nxt = RS_NOTFND;  st_nxt = ST_DONE; o_tm = TM_CANCEL; o_mo = MO_DOWN; end
      K_DATACRC: begin res_nxt = RS_DATACRC; st_nxt = ST_DONE; o_tm = TM_CANCEL; o_mo = MO_DOWN; end
      K_HDRCRC:  begin res_nxt = RS_HDRCRC;  st_nxt = ST_DONE; o_tm = TM_CANCEL; o_mo = MO_DOWN; end
      K_WPROT:   begin res_nxt = RS_WPROT;   st_nxt = ST_DONE; o_tm = TM_CANCEL; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= C_NONE; pcnt_r <= '0; pneed_r <= '0; dbits_r <= '0; adrv_r <= 1'b0;
      st_r <= '0; res_r <= '0; sec_r <= '0; srem_r <= '0; data_r <= '0;
      phase_r <= '0; hw_r <= 1'b0; ver_r <= 1'b0; dout_r <= '0; ovalid_r <= 1'b0;
      for (int i = 0; i < NUM_DRIVES; i++) begin
        ltrk_r[i] <= '0; ptrk_r[i] <= '0;
      end
    end else begin
      if (accept) begin
        cmd_r <= cmd_nxt; pcnt_r <= pcnt_nxt; pneed_r <= pneed_nxt; dbits_r <= dbits_nxt;
        adrv_r <= adrv_nxt; st_r <= st_nxt; res_r <= res_nxt; sec_r <= sec_nxt;
        srem_r <= srem_nxt; data_r <= data_nxt; phase_r <= phase_nxt; hw_r <= hw_nxt;
        ver_r <= ver_nxt; dout_r <= dout_nxt;
        ltrk_r <= ltrk_nxt; ptrk_r <= ptrk_nxt;
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pwe) par_r[pwa] <= wd;
    if (accept)
      odata_r <= {5'd0, o_bo, o_bv, o_mo, o_tm, o_side, o_sec, o_trk, o_drv, o_op,
                  st_nxt[3], o_rd};
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

// ----- sv/fdc_checker.sv -----
// fdc_checker: port-level assertions for the command engine, bound to the top level
// depends on fdc_pkg
module fdc_checker import fdc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // a transaction always yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid) else $error("missing result");

  // ready only drops behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready) else $error("bad ready");

  // byte handoff only on byte wanted transactions
  a_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[3:0] != K_WANT |=> !out_tdata[34])
    else $error("stray byte");

  // bus reads return zero outside read transactions
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[3:0] != K_READ |=> out_tdata[7:0] == 8'd0)
    else $error("stray read data");

endmodule

bind floppy_controller_command_engine fdc_checker u_fdc_checker (.*);
